[hdl/att_pkg.sv]
// att_pkg: shared types, constants and status codes for the allocation tracking table
// no dependencies
package att_pkg;

  localparam int CAPACITY_DEF  = 256;
  localparam int ADDR_BITS_DEF = 48;
  localparam int SIZE_BITS_DEF = 32;
  localparam int CNT_W         = 9;
  localparam int WIDE_W        = 64;
  localparam int STAMP_W       = 32;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_DEALLOC = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_RECORDED  = 3'd0,
    ST_IGNORED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CLEAR,
    S_FINISH,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load;      // capture request, reset scan
    logic    scan;      // advance scan index
    logic    clr_step;  // drop the valid bits, step the clear count
    logic    commit;    // apply the chosen update
    logic    out_load;  // load the result register
    status_t status;
  } att_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic    scan_done;
    logic    clr_done;
    logic    is_alloc;
    logic    is_dealloc;
    logic    is_clear;
    logic    active;    // tracking on and address nonzero
    logic    full;
    logic    found;
  } att_sts_t;

endpackage

[hdl/att_if.sv]
// att_if: valid/ready channel carrying a packed payload
// depends on nothing
interface att_if #(parameter int W = 1) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/allocation_tracking_table_unit.sv]
// channel | dir | payload
// in      | in  | req_type[1:0], address[47:0], alloc_size[31:0]
// out     | out | status, live_count, live_bytes, total_allocs, total_frees,
//         |     | peak_count, peak_rise_bytes
// alloc and dealloc pass from accept through scan and finish: one scan of the
// entry table over its single read port finds the lowest free slot and the newest match.
// clear runs in its own state: valid bits drop at once, then a count runs the table.
// ignored requests skip the scan; idle follows each result before the next accept.
// rst is synchronous; the table holds no data after reset until written.
// the result is held until taken; a new request is accepted in the cycle after that.
// depends on att_pkg, att_if, att_ctrl, att_dp
module allocation_tracking_table_unit import att_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  att_if.sink   in_ch,
  att_if.source out_ch
);

  att_cmd_t cmd;
  att_sts_t sts;
  logic     tracking_on;
  logic [2:0]        status;
  logic [CNT_W-1:0]  live_count, peak_count;
  logic [WIDE_W-1:0] live_bytes, total_allocs, total_frees, peak_rise_bytes;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) tracking_on <= 1'b0;
    else if (cfg_we) tracking_on <= cfg_wdata;
  end

  att_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  att_dp #(.CAPACITY(CAPACITY), .ADDR_BITS(ADDR_BITS), .SIZE_BITS(SIZE_BITS)) u_dp (
    .clk, .rst, .tracking_on,
    .req_type(in_ch.data[SIZE_BITS+ADDR_BITS +: 2]),
    .address(in_ch.data[SIZE_BITS +: ADDR_BITS]),
    .alloc_size(in_ch.data[SIZE_BITS-1:0]),
    .cmd, .sts,
    .status, .live_count, .live_bytes, .total_allocs, .total_frees,
    .peak_count, .peak_rise_bytes
  );

  assign out_ch.data = {status, live_count, live_bytes, total_allocs, total_frees,
                        peak_count, peak_rise_bytes};

endmodule

[hdl/att_ctrl.sv]
// att_ctrl: request sequencer for the allocation tracking table
// depends on att_pkg
module att_ctrl import att_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  att_sts_t sts,
  output att_cmd_t cmd
);

  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_SCAN;
      S_SCAN: begin
        if (sts.is_clear) state_next = S_CLEAR;
        else if (!sts.active || !(sts.is_alloc || sts.is_dealloc)) state_next = S_FINISH;
        else if (sts.scan_done) state_next = S_FINISH;
      end
      S_CLEAR:  if (sts.clr_done) state_next = S_FINISH;
      S_FINISH: state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.status = ST_IGNORED;
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    cmd.load  = (state == S_IDLE) && in_valid;
    unique case (state)
      S_SCAN:  cmd.scan = 1'b1;
      S_CLEAR: cmd.clr_step = 1'b1;
      S_FINISH: begin
        cmd.commit = 1'b1;
        cmd.out_load = 1'b1;
        priority if (sts.is_clear) cmd.status = ST_CLEARED;
        else if (!sts.active || !(sts.is_alloc || sts.is_dealloc)) cmd.status = ST_IGNORED;
        else if (sts.is_alloc) cmd.status = sts.full ? ST_FULL : ST_RECORDED;
        else cmd.status = sts.found ? ST_REMOVED : ST_NOT_FOUND;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

[hdl/att_dp.sv]
// att_dp: entry tables, scan unit and counters of the allocation tracking table
// depends on att_pkg
module att_dp import att_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tracking_on,
  input  logic [1:0]           req_type,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [SIZE_BITS-1:0] alloc_size,
  input  att_cmd_t             cmd,
  output att_sts_t             sts,
  output logic [2:0]           status,
  output logic [CNT_W-1:0]     live_count,
  output logic [WIDE_W-1:0]    live_bytes,
  output logic [WIDE_W-1:0]    total_allocs,
  output logic [WIDE_W-1:0]    total_frees,
  output logic [CNT_W-1:0]     peak_count,
  output logic [WIDE_W-1:0]    peak_rise_bytes
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LC_W  = $clog2(CAPACITY + 1);

  logic [ADDR_BITS-1:0] mem_addr [CAPACITY];
  logic [SIZE_BITS-1:0] mem_size [CAPACITY];
  logic [STAMP_W-1:0]   mem_age  [CAPACITY];
  logic [CAPACITY-1:0]  valid;

  // captured request
  logic [1:0]           rq_type;
  logic [ADDR_BITS-1:0] rq_addr;
  logic [SIZE_BITS-1:0] rq_size;
  logic                 rq_on;

  // scan: index issues reads, data comes back in the following cycle
  logic [LC_W-1:0]      scan_idx;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [STAMP_W-1:0]   rd_age;

  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic [STAMP_W-1:0]   hit_dist;
  logic [SIZE_BITS-1:0] hit_size;

  logic [STAMP_W-1:0]   stamp;
  logic [LC_W-1:0]      live_cnt;
  logic [WIDE_W-1:0]    live_sum, alloc_tot, free_tot, peak_sum;
  logic [LC_W-1:0]      peak_cnt;

  logic [STAMP_W-1:0]   rd_dist;
  logic                 rd_match;
  logic                 rd_better;
  logic                 is_alloc, is_dealloc, active;

  assign is_alloc   = (rq_type == REQ_ALLOC);
  assign is_dealloc = (rq_type == REQ_DEALLOC);
  assign active     = rq_on && (rq_addr != '0);
  assign rd_dist    = stamp - rd_age;
  assign rd_match   = rd_vld && valid[rd_idx] && (rd_addr == rq_addr);
  assign rd_better  = rd_match && (!hit_found || rd_dist < hit_dist);

  assign sts.scan_done  = (scan_idx == LC_W'(CAPACITY)) && !rd_vld;
  assign sts.clr_done   = (scan_idx >= LC_W'(CAPACITY - 1));
  assign sts.is_alloc   = is_alloc;
  assign sts.is_dealloc = is_dealloc;
  assign sts.is_clear   = (rq_type == REQ_CLEAR);
  assign sts.active     = active;
  assign sts.full       = (live_cnt >= LC_W'(CAPACITY)) || !free_found;
  assign sts.found      = hit_found;

  // table memories: one write and one read port each
  always_ff @(posedge clk) begin
    if (cmd.commit && cmd.status == ST_RECORDED) begin
      mem_addr[free_idx] <= rq_addr;
      mem_size[free_idx] <= rq_size;
      mem_age[free_idx]  <= stamp;
    end
    rd_addr <= mem_addr[scan_idx[IDX_W-1:0]];
    rd_age  <= mem_age[scan_idx[IDX_W-1:0]];
    if (cmd.scan && rd_better) hit_size <= mem_size[rd_idx];
  end

  // request capture and scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq_type <= req_type;
      rq_addr <= address;
      rq_size <= alloc_size;
      rq_on   <= tracking_on;
    end
    if (rst) begin
      scan_idx <= '0;
      rd_vld <= 1'b0;
      free_found <= 1'b0;
      hit_found <= 1'b0;
    end else if (cmd.load) begin
      scan_idx <= '0;
      rd_vld <= 1'b0;
      free_found <= 1'b0;
      hit_found <= 1'b0;
    end else if (cmd.clr_step) begin
      scan_idx <= scan_idx + 1'b1;
    end else if (cmd.scan) begin
      rd_vld <= (scan_idx != LC_W'(CAPACITY));
      rd_idx <= scan_idx[IDX_W-1:0];
      if (scan_idx != LC_W'(CAPACITY)) scan_idx <= scan_idx + 1'b1;
      if (!free_found && !valid[scan_idx[IDX_W-1:0]] && scan_idx != LC_W'(CAPACITY)) begin
        free_found <= 1'b1;
        free_idx   <= scan_idx[IDX_W-1:0];
      end
      if (rd_better) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_dist  <= rd_dist;
      end
    end
  end

  // valid bits and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      stamp <= '0;
      live_cnt <= '0;
      live_sum <= '0;
      alloc_tot <= '0;
      free_tot <= '0;
      peak_cnt <= '0;
      peak_sum <= '0;
    end else begin
      if (cmd.clr_step) valid <= '0;
      if (cmd.commit) begin
        unique case (cmd.status)
          ST_CLEARED: begin
            live_cnt <= '0;
            live_sum <= '0;
          end
          ST_RECORDED: begin
            valid[free_idx] <= 1'b1;
            stamp <= stamp + 1'b1;
            live_cnt <= live_cnt + 1'b1;
            live_sum <= live_sum + WIDE_W'(rq_size);
            alloc_tot <= alloc_tot + 1'b1;
            if (live_cnt + 1'b1 > peak_cnt) begin
              peak_cnt <= live_cnt + 1'b1;
              peak_sum <= peak_sum + WIDE_W'(rq_size);
            end
          end
          ST_REMOVED: begin
            valid[hit_idx] <= 1'b0;
            live_cnt <= live_cnt - 1'b1;
            live_sum <= live_sum - WIDE_W'(hit_size);
            free_tot <= free_tot + 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // result register: counters are read in the cycle after commit
  always_ff @(posedge clk) begin
    if (cmd.out_load) status <= cmd.status;
  end
  assign live_count      = CNT_W'(live_cnt);
  assign live_bytes      = live_sum;
  assign total_allocs    = alloc_tot;
  assign total_frees     = free_tot;
  assign peak_count      = CNT_W'(peak_cnt);
  assign peak_rise_bytes = peak_sum;

endmodule

[hdl/att_checker.sv]
// att_checker: port-level assertions for the allocation tracking table
// depends on att_pkg; bound to allocation_tracking_table_unit
module att_checker import att_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [276:0] out_data
);
  // one item in flight: no accept while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("accept while result pending");
  // result stable while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
  // status code in range
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data[276:274] <= ST_CLEARED) else $error("bad status");
  // accepted beat never yields a result next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("early result");
endmodule

bind allocation_tracking_table_unit att_checker u_chk (
  .clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
